// ===== src/cmas_pkg.sv =====
package cmas_pkg;

	localparam int MAX_WINDOW_DEF  = 15;
	localparam int RING_DEPTH_DEF  = 32;
	localparam int VALUE_BITS_DEF  = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int STAMP_W  = 32;
	localparam int WINDOW_W = 4;
	localparam int SEEN_W   = 6;

	localparam logic [WINDOW_W-1:0] WINDOW_RST   = 4'd5;
	localparam logic [SEEN_W-1:0]   SEEN_MAX     = 6'd63;
	localparam logic [SEEN_W-1:0]   SHORT_SERIES = 6'd3;

	// per-item control handed from front to back
	typedef struct packed {
		logic                series_end;
		logic [WINDOW_W-1:0] win;
		logic [SEEN_W-1:0]   seen;
	} cmas_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_SUM,
		ST_PREP,
		ST_DIV,
		ST_OUT
	} cmas_state_t;

endpackage

// ===== src/cmas_if.sv =====
interface cmas_in_if import cmas_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic [STAMP_W-1:0]           stamp;
	logic signed [VALUE_BITS-1:0] rate_value;
	logic                         series_end;

	modport source (output valid, stamp, rate_value, series_end, input ready);
	modport sink (input valid, stamp, rate_value, series_end, output ready);
endinterface

interface cmas_out_if import cmas_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic [STAMP_W-1:0]           out_stamp;
	logic signed [VALUE_BITS-1:0] smoothed;
	logic                         out_last;

	modport source (output valid, out_stamp, smoothed, out_last, input ready);
	modport sink (input valid, out_stamp, smoothed, out_last, output ready);
endinterface

// ===== src/cmas_front.sv =====
module cmas_front import cmas_pkg::*; #(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF,
	parameter int RING_DEPTH = RING_DEPTH_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	localparam int SLOT_W = $clog2(RING_DEPTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [WINDOW_W-1:0]   cfg_wdata,
	cmas_in_if.sink               samples,
	input  logic                  cmd_full,
	output logic                  cmd_push,
	output cmas_ctl_t             cmd_ctl,
	output logic [SLOT_W-1:0]     cmd_wr_slot,
	output logic [SLOT_W-1:0]     cmd_emit_slot,
	output logic [SLOT_W-1:0]     cmd_pending,
	output logic [SLOT_W-1:0]     cmd_count,
	output logic [STAMP_W-1:0]    cmd_stamp,
	output logic [VALUE_BITS-1:0] cmd_value
);

	localparam int W_HALF  = (RING_DEPTH - 1) / 2;
	localparam int W_LIM_A = (MAX_WINDOW < W_HALF) ? MAX_WINDOW : W_HALF;
	localparam int W_LIM   = (W_LIM_A < (2**WINDOW_W - 1)) ? W_LIM_A : (2**WINDOW_W - 1);
	localparam logic [SLOT_W:0] DEPTH_X = (SLOT_W+1)'(RING_DEPTH);

	logic [WINDOW_W-1:0] window_q;
	logic [WINDOW_W-1:0] win_q;
	logic [SEEN_W-1:0]   seen_q;
	logic [SLOT_W-1:0]   wr_q;
	logic [SLOT_W-1:0]   em_q;

	logic                xfer;
	logic [WINDOW_W-1:0] win_lim;
	logic [WINDOW_W-1:0] w_new;
	logic [WINDOW_W-1:0] w_send;
	logic [SEEN_W-1:0]   seen_nx;
	logic [SLOT_W-1:0]   wr_nx;
	logic [SLOT_W:0]     pend_x;
	logic [SLOT_W-1:0]   pending;
	logic [SLOT_W:0]     held_x;
	logic [SLOT_W-1:0]   held;
	logic [SLOT_W-1:0]   count;
	logic [SLOT_W:0]     em_x;
	logic [SLOT_W-1:0]   em_nx;

	assign samples.ready = !cmd_full;
	assign xfer = samples.valid && !cmd_full;

	always_comb begin
		win_lim = (int'(window_q) > W_LIM) ? WINDOW_W'(W_LIM) : window_q;
		w_new   = (seen_q == '0) ? win_lim : win_q;
		seen_nx = (seen_q == SEEN_MAX) ? seen_q : seen_q + 1'b1;
		wr_nx   = (wr_q == SLOT_W'(RING_DEPTH - 1)) ? '0 : wr_q + 1'b1;
		pend_x  = {1'b0, wr_nx} + DEPTH_X - {1'b0, em_q};
		pending = (pend_x >= DEPTH_X) ? SLOT_W'(pend_x - DEPTH_X) : SLOT_W'(pend_x);
		held_x  = {1'b0, wr_q} + DEPTH_X - {1'b0, em_q};
		held    = (held_x >= DEPTH_X) ? SLOT_W'(held_x - DEPTH_X) : SLOT_W'(held_x);
		w_send  = w_new;
		count   = '0;
		if (samples.series_end) begin
			count = pending;
			// short series: pass samples through unchanged
			if (seen_nx < SHORT_SERIES) begin
				w_send = '0;
			end
		end else if (seen_nx >= SHORT_SERIES && int'(pending) > int'(w_new)) begin
			count = pending - SLOT_W'(w_new);
		end
		em_x  = {1'b0, em_q} + {1'b0, count};
		em_nx = (em_x >= DEPTH_X) ? SLOT_W'(em_x - DEPTH_X) : SLOT_W'(em_x);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RST;
			win_q    <= '0;
			seen_q   <= '0;
			wr_q     <= '0;
			em_q     <= '0;
		end else begin
			if (cfg_we) begin
				window_q <= cfg_wdata;
			end
			if (xfer) begin
				if (samples.series_end) begin
					win_q  <= '0;
					seen_q <= '0;
					wr_q   <= '0;
					em_q   <= '0;
				end else begin
					win_q  <= w_new;
					seen_q <= seen_nx;
					wr_q   <= wr_nx;
					em_q   <= em_nx;
				end
			end
		end
	end

	assign cmd_push      = xfer;
	assign cmd_ctl       = '{series_end: samples.series_end, win: w_send, seen: seen_nx};
	assign cmd_wr_slot   = wr_q;
	assign cmd_emit_slot = em_q;
	assign cmd_pending   = pending;
	assign cmd_count     = count;
	assign cmd_stamp     = samples.stamp;
	assign cmd_value     = samples.rate_value;

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && samples.series_end |=> seen_q == '0 && wr_q == '0 && em_q == '0)
		else $error("series state not cleared after last sample");

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q >= SHORT_SERIES |-> int'(held) <= int'(win_q))
		else $error("more samples held than the window needs");

	a_short_holds: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && !samples.series_end && seen_nx < SHORT_SERIES |-> count == '0)
		else $error("result issued before the series is long enough");

endmodule

// ===== src/cmas_queue.sv =====
module cmas_queue import cmas_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH_DEF,
	localparam int PTR_W = $clog2(DEPTH),
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] fill_q;

	logic do_push;
	logic do_pop;

	assign full     = (fill_q == CNT_W'(DEPTH));
	assign empty    = (fill_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== src/cmas_back.sv =====
module cmas_back import cmas_pkg::*; #(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF,
	parameter int RING_DEPTH = RING_DEPTH_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	localparam int SLOT_W = $clog2(RING_DEPTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_empty,
	output logic                  cmd_pop,
	input  cmas_ctl_t             cmd_ctl,
	input  logic [SLOT_W-1:0]     cmd_wr_slot,
	input  logic [SLOT_W-1:0]     cmd_emit_slot,
	input  logic [SLOT_W-1:0]     cmd_pending,
	input  logic [SLOT_W-1:0]     cmd_count,
	input  logic [STAMP_W-1:0]    cmd_stamp,
	input  logic [VALUE_BITS-1:0] cmd_value,
	cmas_out_if.source            results
);

	localparam int W_HALF  = (RING_DEPTH - 1) / 2;
	localparam int W_LIM_A = (MAX_WINDOW < W_HALF) ? MAX_WINDOW : W_HALF;
	localparam int W_LIM   = (W_LIM_A < (2**WINDOW_W - 1)) ? W_LIM_A : (2**WINDOW_W - 1);
	localparam int CNT_MAX = 2 * W_LIM + 1;
	localparam int CNT_W   = $clog2(CNT_MAX + 1);
	localparam int SUM_W   = VALUE_BITS + CNT_W;
	localparam int BIT_W   = $clog2(SUM_W + 1);
	localparam logic [SLOT_W:0] DEPTH_X = (SLOT_W+1)'(RING_DEPTH);

	logic [VALUE_BITS-1:0] value_ring [RING_DEPTH];
	logic [STAMP_W-1:0]    stamp_ring [RING_DEPTH];

	cmas_state_t           state_q, state_d;
	cmas_ctl_t             ctl_q, ctl_d;
	logic [SLOT_W-1:0]     cur_q, cur_d;
	logic [SLOT_W-1:0]     pend_q, pend_d;
	logic [SLOT_W-1:0]     left_cnt_q, left_cnt_d;
	logic [SLOT_W-1:0]     rd_addr_q, rd_addr_d;
	logic [CNT_W-1:0]      rd_cnt_q, rd_cnt_d;
	logic [CNT_W-1:0]      cnt_q, cnt_d;
	logic                  data_vld_q, data_vld_d;
	logic [SUM_W-1:0]      acc_q, acc_d;
	logic                  neg_q, neg_d;
	logic [SUM_W-1:0]      div_q, div_d;
	logic [CNT_W-1:0]      rem_q, rem_d;
	logic [BIT_W-1:0]      bit_q, bit_d;
	logic [VALUE_BITS-1:0] rd_val_q;
	logic [STAMP_W-1:0]    rd_stamp_q;
	logic                  out_vld_q, out_vld_d;
	logic [STAMP_W-1:0]    out_stamp_q, out_stamp_d;
	logic [VALUE_BITS-1:0] out_val_q, out_val_d;
	logic                  out_last_q, out_last_d;

	logic                  ring_we;
	logic                  val_re;
	logic                  stamp_re;
	logic [SEEN_W-1:0]     centre;
	logic [SLOT_W-1:0]     pend_m1;
	logic [WINDOW_W-1:0]   left;
	logic [WINDOW_W-1:0]   right;
	logic [SLOT_W:0]       rs_x;
	logic [CNT_W:0]        trial;
	logic [SUM_W-1:0]      mag;
	logic [SUM_W-1:0]      quo;

	always_ff @(posedge clk) begin
		if (ring_we) begin
			value_ring[cmd_wr_slot] <= cmd_value;
			stamp_ring[cmd_wr_slot] <= cmd_stamp;
		end
		if (val_re) begin
			rd_val_q <= value_ring[rd_addr_q];
		end
		if (stamp_re) begin
			rd_stamp_q <= stamp_ring[cur_q];
		end
	end

	always_comb begin
		state_d     = state_q;
		ctl_d       = ctl_q;
		cur_d       = cur_q;
		pend_d      = pend_q;
		left_cnt_d  = left_cnt_q;
		rd_addr_d   = rd_addr_q;
		rd_cnt_d    = rd_cnt_q;
		cnt_d       = cnt_q;
		data_vld_d  = data_vld_q;
		acc_d       = acc_q;
		neg_d       = neg_q;
		div_d       = div_q;
		rem_d       = rem_q;
		bit_d       = bit_q;
		out_vld_d   = out_vld_q && !results.ready;
		out_stamp_d = out_stamp_q;
		out_val_d   = out_val_q;
		out_last_d  = out_last_q;
		cmd_pop     = 1'b0;
		ring_we     = 1'b0;
		val_re      = 1'b0;
		stamp_re    = 1'b0;

		centre  = ctl_q.seen - SEEN_W'(pend_q);
		pend_m1 = pend_q - 1'b1;
		left    = (centre < SEEN_W'(ctl_q.win)) ? WINDOW_W'(centre) : ctl_q.win;
		right   = (SEEN_W'(pend_m1) < SEEN_W'(ctl_q.win)) ? WINDOW_W'(pend_m1) : ctl_q.win;
		rs_x    = {1'b0, cur_q} + DEPTH_X - (SLOT_W+1)'(left);
		trial   = {rem_q, div_q[SUM_W-1]};
		mag     = acc_q[SUM_W-1] ? (~acc_q + 1'b1) : acc_q;
		quo     = neg_q ? (~div_q + 1'b1) : div_q;

		case (state_q)
			ST_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop    = 1'b1;
					ring_we    = 1'b1;
					ctl_d      = cmd_ctl;
					cur_d      = cmd_emit_slot;
					pend_d     = cmd_pending;
					left_cnt_d = cmd_count;
					state_d    = (cmd_count != '0) ? ST_SETUP : ST_IDLE;
				end
			end
			ST_SETUP: begin
				stamp_re   = 1'b1;
				cnt_d      = CNT_W'(left) + CNT_W'(right) + 1'b1;
				rd_cnt_d   = CNT_W'(left) + CNT_W'(right) + 1'b1;
				rd_addr_d  = (rs_x >= DEPTH_X) ? SLOT_W'(rs_x - DEPTH_X) : SLOT_W'(rs_x);
				acc_d      = '0;
				data_vld_d = 1'b0;
				state_d    = ST_SUM;
			end
			ST_SUM: begin
				if (rd_cnt_q != '0) begin
					val_re    = 1'b1;
					rd_cnt_d  = rd_cnt_q - 1'b1;
					rd_addr_d = (rd_addr_q == SLOT_W'(RING_DEPTH - 1)) ? '0 : rd_addr_q + 1'b1;
				end
				data_vld_d = (rd_cnt_q != '0);
				if (data_vld_q) begin
					acc_d = acc_q + {{CNT_W{rd_val_q[VALUE_BITS-1]}}, rd_val_q};
				end
				if (rd_cnt_q == '0) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				// round half away from zero: divide |sum| + count/2
				neg_d   = acc_q[SUM_W-1];
				div_d   = mag + SUM_W'(cnt_q >> 1);
				rem_d   = '0;
				bit_d   = BIT_W'(SUM_W);
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (trial >= {1'b0, cnt_q}) begin
					rem_d = CNT_W'(trial - {1'b0, cnt_q});
					div_d = {div_q[SUM_W-2:0], 1'b1};
				end else begin
					rem_d = CNT_W'(trial);
					div_d = {div_q[SUM_W-2:0], 1'b0};
				end
				bit_d = bit_q - 1'b1;
				if (bit_q == BIT_W'(1)) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_vld_q || results.ready) begin
					out_vld_d   = 1'b1;
					out_stamp_d = rd_stamp_q;
					out_val_d   = quo[VALUE_BITS-1:0];
					out_last_d  = ctl_q.series_end && (pend_q == SLOT_W'(1));
					cur_d       = (cur_q == SLOT_W'(RING_DEPTH - 1)) ? '0 : cur_q + 1'b1;
					pend_d      = pend_m1;
					left_cnt_d  = left_cnt_q - 1'b1;
					state_d     = (left_cnt_q == SLOT_W'(1)) ? ST_IDLE : ST_SETUP;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			out_vld_q <= out_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		ctl_q       <= ctl_d;
		cur_q       <= cur_d;
		pend_q      <= pend_d;
		left_cnt_q  <= left_cnt_d;
		rd_addr_q   <= rd_addr_d;
		rd_cnt_q    <= rd_cnt_d;
		cnt_q       <= cnt_d;
		data_vld_q  <= data_vld_d;
		acc_q       <= acc_d;
		neg_q       <= neg_d;
		div_q       <= div_d;
		rem_q       <= rem_d;
		bit_q       <= bit_d;
		out_stamp_q <= out_stamp_d;
		out_val_q   <= out_val_d;
		out_last_q  <= out_last_d;
	end

	assign results.valid     = out_vld_q;
	assign results.out_stamp = out_stamp_q;
	assign results.smoothed  = out_val_q;
	assign results.out_last  = out_last_q;

	a_last_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SUM && rd_cnt_q == '0 |-> data_vld_q)
		else $error("window sum closed without its last sample");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < cnt_q)
		else $error("divider remainder not below divisor");

	a_setup_ok: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SETUP |-> pend_q != '0 && left_cnt_q != '0 && left_cnt_q <= pend_q)
		else $error("result requested with no sample pending");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT && (!out_vld_q || results.ready) |=> results.valid)
		else $error("finished result not presented");

endmodule

// ===== src/centered_moving_average_smoother.sv =====
// Centered moving average over a series of timestamped rate samples.
// samples: valid/ready input channel, one sample (stamp, rate_value, series_end)
//   per transfer. results: valid/ready output channel, one result per sample, in
//   order, same stamp, value replaced by the rounded mean of the sample and up to
//   window neighbours each side (window shrinks at the series edges; a series of
//   fewer than three samples comes back unchanged). out_last marks the result of
//   the final sample.
// cfg_we/cfg_wdata write the window register (reset 5); it is taken at the first
//   sample of each series.
// Release: a result leaves once window later samples and at least three samples of the
//   series have arrived, or when the last sample of the series flushes all held samples.
// Throughput: the front takes one sample per cycle while the queue is not full, into a
//   4-entry command queue. The back pops one command per sample and finishes its results
//   before it takes the next command; each result sums the samples in its window, one ring
//   read per sample, and a bit-serial divider divides by their count.
// Reset: all series state clears, no results pending, window returns to 5.
// Stalls: a result waits in the output register; the back halts behind it and
//   samples keep flowing in until the queue is full.
module centered_moving_average_smoother import cmas_pkg::*; #(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF,
	parameter int RING_DEPTH = RING_DEPTH_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [WINDOW_W-1:0] cfg_wdata,
	cmas_in_if.sink             samples,
	cmas_out_if.source          results
);

	localparam int SLOT_W = $clog2(RING_DEPTH);
	localparam int CMD_W  = $bits(cmas_ctl_t) + 4 * SLOT_W + STAMP_W + VALUE_BITS;

	logic                  push;
	logic                  full;
	logic                  pop;
	logic                  empty;
	logic [CMD_W-1:0]      push_data;
	logic [CMD_W-1:0]      pop_data;

	cmas_ctl_t             f_ctl, b_ctl;
	logic [SLOT_W-1:0]     f_wr, f_em, f_pend, f_cnt;
	logic [SLOT_W-1:0]     b_wr, b_em, b_pend, b_cnt;
	logic [STAMP_W-1:0]    f_stamp, b_stamp;
	logic [VALUE_BITS-1:0] f_value, b_value;

	cmas_front #(
		.MAX_WINDOW (MAX_WINDOW),
		.RING_DEPTH (RING_DEPTH),
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.samples       (samples),
		.cmd_full      (full),
		.cmd_push      (push),
		.cmd_ctl       (f_ctl),
		.cmd_wr_slot   (f_wr),
		.cmd_emit_slot (f_em),
		.cmd_pending   (f_pend),
		.cmd_count     (f_cnt),
		.cmd_stamp     (f_stamp),
		.cmd_value     (f_value)
	);

	assign push_data = {f_ctl, f_wr, f_em, f_pend, f_cnt, f_stamp, f_value};

	cmas_queue #(
		.WIDTH (CMD_W),
		.DEPTH (QUEUE_DEPTH_DEF)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	assign {b_ctl, b_wr, b_em, b_pend, b_cnt, b_stamp, b_value} = pop_data;

	cmas_back #(
		.MAX_WINDOW (MAX_WINDOW),
		.RING_DEPTH (RING_DEPTH),
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_empty     (empty),
		.cmd_pop       (pop),
		.cmd_ctl       (b_ctl),
		.cmd_wr_slot   (b_wr),
		.cmd_emit_slot (b_em),
		.cmd_pending   (b_pend),
		.cmd_count     (b_cnt),
		.cmd_stamp     (b_stamp),
		.cmd_value     (b_value),
		.results       (results)
	);

endmodule
